// ----- hdl/sgr_pkg.sv -----
// Shared types and constants of the streaming 3x3 Sobel gradient filter.
package sgr_pkg;

	// Fixed field widths of the block's ports.
	localparam int PIXEL_IN_BITS = 8;
	localparam int GRAD_BITS     = 11;
	localparam int CFG_BITS      = 11;

	// Configuration register indexes.
	localparam logic REG_IMAGE_WIDTH   = 1'b0;
	localparam logic REG_GRADIENT_AXIS = 1'b1;

	// Gradient axis codes.
	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RESET = 11'd1024;

	// Indexes into a 3x3 neighborhood: rows above, center, below; columns left, middle, right.
	localparam int ROW_A = 0;
	localparam int ROW_M = 1;
	localparam int ROW_B = 2;
	localparam int COL_L = 0;
	localparam int COL_M = 1;
	localparam int COL_R = 2;

	// Entries in the queue between the window builder and the arithmetic.
	localparam int JOB_QUEUE_DEPTH = 4;

	// Per-job control carried alongside the neighborhood.
	typedef struct packed {
		logic two;        // a second result follows, with the right column replicated
		logic row_end;    // marks the first result as the end of a row
		logic image_end;  // marks the first result as the end of the image
	} job_flags_t;

endpackage

// ----- hdl/sgr_ram.sv -----
// Generic single-write, dual-read RAM with registered, write-first read ports.
module sgr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
		rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
	end

endmodule

// ----- hdl/sgr_front.sv -----
// Front end: accepts pixels and drain requests, keeps the line store and builds neighborhoods.
module sgr_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [sgr_pkg::PIXEL_IN_BITS-1:0]   pixel_value,
	input  logic                                drain,
	input  logic [$clog2(MAX_WIDTH)-1:0]        last_col,
	output logic                                job_valid,
	output sgr_pkg::job_flags_t                 job_flags,
	output logic [2:0][2:0][PIXEL_BITS-1:0]     job_pix
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PB = PIXEL_BITS;
	localparam logic [1:0] ROWS_MAX = 2'd2;

	logic [AW-1:0] col_q;
	logic [AW-1:0] col_eff;
	logic [AW-1:0] col_next;
	logic [AW-1:0] addr_b;
	logic [1:0]    rows_seen_q;
	logic          draining_q;
	logic          is_last;
	logic          drain_ok;
	logic          take_drain;
	logic          take_pixel;

	logic          valid_s1;
	logic          drain_s1;
	logic          emit_s1;
	logic          col_one_s1;
	logic          first_s1;
	logic          last_s1;
	logic          rows_one_s1;
	logic [AW-1:0] addr_s1;
	logic [PB-1:0] px_s1;

	logic [2*PB-1:0] rd_a;
	logic [2*PB-1:0] rd_b;
	logic [2*PB-1:0] wr_data;
	logic            wr_en;
	logic [PB-1:0]   cen_a;
	logic [PB-1:0]   abv_a;
	logic [PB-1:0]   cen_b;
	logic [PB-1:0]   abv_b;

	logic [1:0][PB-1:0] win_a_q;
	logic [1:0][PB-1:0] win_m_q;
	logic [1:0][PB-1:0] win_b_q;
	logic [PB-1:0]      left_a_q;
	logic [PB-1:0]      left_m_q;

	// A column count left past the row end by a width change counts as the last column.
	assign col_eff    = (col_q > last_col) ? last_col : col_q;
	assign is_last    = (col_eff == last_col);
	assign col_next   = is_last ? '0 : AW'(col_eff + 1'b1);
	assign addr_b     = is_last ? col_eff : col_next;
	assign drain_ok   = draining_q || (rows_seen_q != 2'd0 && col_q == '0);
	assign take_drain = accept && drain && drain_ok;
	assign take_pixel = accept && !drain && !draining_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			rows_seen_q <= '0;
			draining_q  <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= take_drain || take_pixel;
			if (take_drain) begin
				draining_q <= !is_last;
				col_q      <= col_next;
				if (is_last) begin
					rows_seen_q <= '0;
				end
			end else if (take_pixel) begin
				col_q <= col_next;
				if (is_last && rows_seen_q != ROWS_MAX) begin
					rows_seen_q <= rows_seen_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_drain || take_pixel) begin
			drain_s1    <= drain;
			emit_s1     <= (rows_seen_q != 2'd0) && (col_eff != '0);
			col_one_s1  <= (col_eff == AW'(1));
			first_s1    <= (col_eff == '0);
			last_s1     <= is_last;
			rows_one_s1 <= (rows_seen_q == 2'd1);
			addr_s1     <= col_eff;
			px_s1       <= PB'(pixel_value);
		end
	end

	// Each entry holds {row above, center row} of one column.
	sgr_ram #(
		.WIDTH(2 * PB),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (addr_s1),
		.wdata   (wr_data),
		.raddr_a (col_eff),
		.rdata_a (rd_a),
		.raddr_b (addr_b),
		.rdata_b (rd_b)
	);

	// On the second row the row above is the first row itself.
	assign cen_a   = rd_a[PB-1:0];
	assign abv_a   = rows_one_s1 ? cen_a : rd_a[2*PB-1:PB];
	assign cen_b   = rd_b[PB-1:0];
	assign abv_b   = rows_one_s1 ? cen_b : rd_b[2*PB-1:PB];
	assign wr_en   = valid_s1 && !drain_s1;
	assign wr_data = {cen_a, px_s1};

	always_ff @(posedge clk) begin
		if (valid_s1 && !drain_s1) begin
			win_a_q <= {abv_a, win_a_q[1]};
			win_m_q <= {cen_a, win_m_q[1]};
			win_b_q <= {px_s1, win_b_q[1]};
		end
		if (valid_s1 && drain_s1) begin
			left_a_q <= abv_a;
			left_m_q <= cen_a;
		end
	end

	always_comb begin
		job_pix   = '0;
		job_flags = '0;
		if (drain_s1) begin
			job_pix[sgr_pkg::ROW_A][sgr_pkg::COL_L] = first_s1 ? abv_a : left_a_q;
			job_pix[sgr_pkg::ROW_A][sgr_pkg::COL_M] = abv_a;
			job_pix[sgr_pkg::ROW_A][sgr_pkg::COL_R] = abv_b;
			job_pix[sgr_pkg::ROW_M][sgr_pkg::COL_L] = first_s1 ? cen_a : left_m_q;
			job_pix[sgr_pkg::ROW_M][sgr_pkg::COL_M] = cen_a;
			job_pix[sgr_pkg::ROW_M][sgr_pkg::COL_R] = cen_b;
			job_pix[sgr_pkg::ROW_B] = job_pix[sgr_pkg::ROW_M];
			job_flags.row_end   = last_s1;
			job_flags.image_end = last_s1;
		end else begin
			job_pix[sgr_pkg::ROW_A][sgr_pkg::COL_L] = col_one_s1 ? win_a_q[1] : win_a_q[0];
			job_pix[sgr_pkg::ROW_A][sgr_pkg::COL_M] = win_a_q[1];
			job_pix[sgr_pkg::ROW_A][sgr_pkg::COL_R] = abv_a;
			job_pix[sgr_pkg::ROW_M][sgr_pkg::COL_L] = col_one_s1 ? win_m_q[1] : win_m_q[0];
			job_pix[sgr_pkg::ROW_M][sgr_pkg::COL_M] = win_m_q[1];
			job_pix[sgr_pkg::ROW_M][sgr_pkg::COL_R] = cen_a;
			job_pix[sgr_pkg::ROW_B][sgr_pkg::COL_L] = col_one_s1 ? win_b_q[1] : win_b_q[0];
			job_pix[sgr_pkg::ROW_B][sgr_pkg::COL_M] = win_b_q[1];
			job_pix[sgr_pkg::ROW_B][sgr_pkg::COL_R] = px_s1;
			job_flags.two = last_s1;
		end
	end

	assign job_valid = valid_s1 && (drain_s1 || emit_s1);

`ifndef ASSERT_OFF
	a_drain_needs_rows: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> rows_seen_q != 2'd0)
		else $error("draining with no stored row");
`endif

endmodule

// ----- hdl/sgr_queue.sv -----
// Small register queue between the window builder and the arithmetic.
module sgr_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             not_empty,
	output logic             almost_full
);

	localparam int IW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IW-1:0]    wr_ptr_q;
	logic [IW-1:0]    rd_ptr_q;
	logic [IW:0]      count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data     = mem_q[rd_ptr_q];
	assign not_empty   = (count_q != '0);
	// One slot is held back for the entry already in flight behind the line store.
	assign almost_full = (count_q >= (IW+1)'(DEPTH - 1));

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |-> count_q != (IW+1)'(DEPTH))
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> count_q != '0)
		else $error("job queue underflow");
`endif

endmodule

// ----- hdl/sgr_back.sv -----
// Back end: evaluates the Sobel kernel on queued neighborhoods and holds the result register.
module sgr_back #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   axis,
	input  logic                                   job_valid,
	input  sgr_pkg::job_flags_t                    job_flags,
	input  logic [2:0][2:0][PIXEL_BITS-1:0]        job_pix,
	output logic                                   job_pop,
	input  logic                                   pop,
	output logic                                   empty,
	output logic signed [sgr_pkg::GRAD_BITS-1:0]   gradient,
	output logic                                   row_end,
	output logic                                   image_end
);

	localparam int SW = PIXEL_BITS + 4;

	logic                                 phase_q;
	logic                                 out_valid_q;
	logic                                 out_ready;
	logic                                 fire;
	logic                                 last_part;
	logic signed [SW-1:0]                 lv [3];
	logic signed [SW-1:0]                 mv [3];
	logic signed [SW-1:0]                 rv [3];
	logic signed [SW-1:0]                 sum;
	logic signed [sgr_pkg::GRAD_BITS-1:0] grad;

	function automatic logic signed [SW-1:0] widen(input logic [PIXEL_BITS-1:0] v);
		return $signed(SW'(v));
	endfunction

	// The second result of a row end shifts the window left and replicates the right column.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			lv[r] = widen(phase_q ? job_pix[r][sgr_pkg::COL_M] : job_pix[r][sgr_pkg::COL_L]);
			mv[r] = widen(phase_q ? job_pix[r][sgr_pkg::COL_R] : job_pix[r][sgr_pkg::COL_M]);
			rv[r] = widen(job_pix[r][sgr_pkg::COL_R]);
		end
	end

	always_comb begin
		if (axis == sgr_pkg::AXIS_Y) begin
			sum = (lv[sgr_pkg::ROW_A] + (mv[sgr_pkg::ROW_A] <<< 1) + rv[sgr_pkg::ROW_A])
			    - (lv[sgr_pkg::ROW_B] + (mv[sgr_pkg::ROW_B] <<< 1) + rv[sgr_pkg::ROW_B]);
		end else begin
			sum = (lv[sgr_pkg::ROW_A] - rv[sgr_pkg::ROW_A])
			    + ((lv[sgr_pkg::ROW_M] - rv[sgr_pkg::ROW_M]) <<< 1)
			    + (lv[sgr_pkg::ROW_B] - rv[sgr_pkg::ROW_B]);
		end
		grad = sgr_pkg::GRAD_BITS'(sum);
	end

	assign out_ready = !out_valid_q || pop;
	assign fire      = job_valid && out_ready;
	assign last_part = !job_flags.two || phase_q;
	assign job_pop   = fire && last_part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q     <= !last_part;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			gradient  <= grad;
			row_end   <= phase_q ? 1'b1 : job_flags.row_end;
			image_end <= phase_q ? 1'b0 : job_flags.image_end;
		end
	end

	assign empty = !out_valid_q;

`ifndef ASSERT_OFF
	a_phase_holds_job: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> job_valid)
		else $error("second result pending without its job");
`endif

endmodule

// ----- hdl/sobel_gradient_3x3_top.sv -----
// Top level of the streaming 3x3 Sobel gradient filter.
//
// Streams raster pixels in through a queue-style push port and returns signed 3x3 Sobel
// responses through a queue-style pop port, one pixel per clock cycle when not full. Each
// accepted pixel request at column c of row r yields the result for column c-1 of row r-1,
// and the last pixel of a row also yields the result for the row's last column, so a row of
// w pixels gives w results; the first row of an image gives none. Image borders replicate
// the edge pixel. Because the image height is not known, the last row is flushed by w drain
// requests, one result each, the final one flagged image_end, after which the block is armed
// for a new image. Drain requests before a full row or in mid-row, and pixels sent while
// draining, are taken and dropped. A request passes a stage register, the job queue and the
// result register; a row-end pixel's second result follows its first. The pace is set
// by the line store, one RAM with one write and two read ports, touched once per request.
// Results wait in a four-entry job queue and a result register, so full rises only once
// three jobs are waiting on a stalled consumer. The line store is not cleared after reset,
// and no result ever reads an entry that was not written. image_width (clamped to
// 2..MAX_WIDTH) and gradient_axis (0 horizontal, 1 vertical) are to be written through the
// cfg port only while the block is idle; the block itself does not enforce this.
module sobel_gradient_3x3_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [sgr_pkg::PIXEL_IN_BITS-1:0]    pixel_value,
	input  logic                                 drain,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [sgr_pkg::GRAD_BITS-1:0] gradient,
	output logic                                 row_end,
	output logic                                 image_end,
	input  logic                                 cfg_write,
	input  logic                                 cfg_index,
	input  logic [sgr_pkg::CFG_BITS-1:0]         cfg_data
);

	localparam int AW       = $clog2(MAX_WIDTH);
	localparam int JOB_BITS = 9 * PIXEL_BITS + $bits(sgr_pkg::job_flags_t);

	logic [sgr_pkg::CFG_BITS-1:0] image_width_q;
	logic                         gradient_axis_q;
	logic [AW-1:0]                last_col;
	logic                         accept;

	logic                                front_valid;
	sgr_pkg::job_flags_t                 front_flags;
	logic [2:0][2:0][PIXEL_BITS-1:0]     front_pix;
	logic [JOB_BITS-1:0]                 queue_data;
	logic                                queue_valid;
	logic                                queue_afull;
	logic                                back_pop;
	sgr_pkg::job_flags_t                 back_flags;
	logic [2:0][2:0][PIXEL_BITS-1:0]     back_pix;

	// Config registers; write only while the block is idle; the block does not check it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= sgr_pkg::IMAGE_WIDTH_RESET;
			gradient_axis_q <= sgr_pkg::AXIS_X;
		end else if (cfg_write) begin
			case (cfg_index)
				sgr_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data;
				end
				sgr_pkg::REG_GRADIENT_AXIS: begin
					gradient_axis_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Index of the last column in use, with the width clamped to 2..MAX_WIDTH.
	always_comb begin
		if (image_width_q < 11'd2) begin
			last_col = AW'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			last_col = AW'(MAX_WIDTH - 1);
		end else begin
			last_col = AW'(image_width_q - 11'd1);
		end
	end

	assign full   = queue_afull;
	assign accept = push && !full;

	sgr_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.pixel_value (pixel_value),
		.drain       (drain),
		.last_col    (last_col),
		.job_valid   (front_valid),
		.job_flags   (front_flags),
		.job_pix     (front_pix)
	);

	sgr_queue #(
		.WIDTH (JOB_BITS),
		.DEPTH (sgr_pkg::JOB_QUEUE_DEPTH)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (front_valid),
		.wr_data     ({front_flags, front_pix}),
		.rd_en       (back_pop),
		.rd_data     (queue_data),
		.not_empty   (queue_valid),
		.almost_full (queue_afull)
	);

	assign {back_flags, back_pix} = queue_data;

	sgr_back #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.axis      (gradient_axis_q),
		.job_valid (queue_valid),
		.job_flags (back_flags),
		.job_pix   (back_pix),
		.job_pop   (back_pop),
		.pop       (pop),
		.empty     (empty),
		.gradient  (gradient),
		.row_end   (row_end),
		.image_end (image_end)
	);

`ifndef ASSERT_OFF
	a_job_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid |-> $past(push && !full))
		else $error("job produced without an accepted request");
`endif

endmodule
